// ----- rtl/hfp_pkg.sv -----
// Shared constants, status codes and the front-to-back command type for the
// hex float string parser. No dependencies.
package hfp_pkg;

   localparam int CHAR_W   = 8;
   localparam int VAL_W    = 64;
   localparam int FRAC_W   = 32;
   localparam int STATUS_W = 2;
   localparam int DIGIT_W  = 9;
   localparam int OP_W     = 3;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_0X  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_P   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUTRUN = 2'd3;

   // back-end operations
   localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
   localparam logic [OP_W-1:0] OP_MANT_LOAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_MANT_SHIFT = 3'd2;
   localparam logic [OP_W-1:0] OP_EXP_LOAD   = 3'd3;
   localparam logic [OP_W-1:0] OP_EXP_STEP   = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_P  = 8'h70;
   localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

   // digit already carries the sign of the quantity it feeds
   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic signed [DIGIT_W-1:0]  digit;
      logic                       last;
      logic [STATUS_W-1:0]        status;
   } hfp_cmd_type;

endpackage

// ----- rtl/hfp_req_if.sv -----
// Byte input channel: valid/ready with one string byte and its end flag.
// Depends on hfp_pkg.
interface hfp_req_if;
   import hfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/hfp_rsp_if.sv -----
// Result channel: valid/ready with mantissa, binary exponent and status.
// Depends on hfp_pkg.
interface hfp_rsp_if;
   import hfp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  mantissa;
   logic signed [VAL_W-1:0]  exponent;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output mantissa, output exponent, output status,
                   input ready);
   modport sink   (input valid, input mantissa, input exponent, input status,
                   output ready);
endinterface

// ----- rtl/hfp_front.sv -----
// Front end: takes string bytes, tracks the parse phase and emits one command
// per byte that does work or is the last byte. Depends on hfp_pkg.
module hfp_front (
   input  logic                 clock,
   input  logic                 reset,
   hfp_req_if.sink              req_if,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output hfp_pkg::hfp_cmd_type cmd
);
   import hfp_pkg::*;

   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_ZERO  = 4'd1;
   localparam logic [3:0] PH_X     = 4'd2;
   localparam logic [3:0] PH_LEAD  = 4'd3;
   localparam logic [3:0] PH_DOT   = 4'd4;
   localparam logic [3:0] PH_FRAC  = 4'd5;
   localparam logic [3:0] PH_ESIGN = 4'd6;
   localparam logic [3:0] PH_EXP   = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   logic [3:0]          phase_ff, phase_in, phase_nx;
   logic                mneg_ff, mneg_in, mneg_nx;
   logic                eneg_ff, eneg_in, eneg_nx;
   logic                mismatch_ff, mismatch_in, mismatch_nx;
   logic [STATUS_W-1:0] outcome_ff, outcome_in, outcome_nx;

   logic                    accept;
   logic [CHAR_W-1:0]       c;
   logic [OP_W-1:0]         op;
   logic signed [DIGIT_W-1:0] hex_raw, dec_raw, raw;
   logic                    use_eneg;

   assign req_if.ready = !cmd_full;
   assign accept       = req_if.valid && !cmd_full;
   assign c            = req_if.char_code;

   always_comb begin
      if (c >= CH_LC_A) begin
         hex_raw = $signed({1'b0, c}) - 9'sd87;
      end else begin
         hex_raw = $signed({1'b0, c}) - 9'sd48;
      end
      dec_raw = $signed({1'b0, c}) - 9'sd48;
   end

   always_comb begin
      phase_nx    = phase_ff;
      mneg_nx     = mneg_ff;
      eneg_nx     = eneg_ff;
      mismatch_nx = mismatch_ff;
      outcome_nx  = outcome_ff;
      op          = OP_NONE;
      raw         = hex_raw;
      use_eneg    = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (c == CH_MINUS) begin
               mneg_nx  = 1'b1;
               phase_nx = PH_ZERO;
            end else begin
               if (c != CH_ZERO) mismatch_nx = 1'b1;
               phase_nx = PH_X;
            end
         end
         PH_ZERO: begin
            if (c != CH_ZERO) mismatch_nx = 1'b1;
            phase_nx = PH_X;
         end
         PH_X: begin
            if (c != CH_LC_X) mismatch_nx = 1'b1;
            phase_nx = PH_LEAD;
         end
         PH_LEAD: begin
            if (mismatch_ff) begin
               phase_nx   = PH_DONE;
               outcome_nx = ST_NO_0X;
            end else begin
               op       = OP_MANT_LOAD;
               phase_nx = PH_DOT;
            end
         end
         PH_DOT: begin
            if (c == CH_DOT) begin
               if (req_if.last_char) begin
                  phase_nx   = PH_DONE;
                  outcome_nx = ST_NO_P;
               end else begin
                  phase_nx = PH_FRAC;
               end
            end else if (c == CH_LC_P) begin
               phase_nx = PH_ESIGN;
            end else begin
               phase_nx   = PH_DONE;
               outcome_nx = ST_NO_P;
            end
         end
         PH_FRAC: begin
            if (c == CH_LC_P) begin
               phase_nx = PH_ESIGN;
            end else begin
               op = OP_MANT_SHIFT;
               if (req_if.last_char) begin
                  phase_nx   = PH_DONE;
                  outcome_nx = ST_NO_P;
               end
            end
         end
         PH_ESIGN: begin
            raw = dec_raw;
            if (c == CH_MINUS) begin
               eneg_nx  = 1'b1;
               phase_nx = PH_EXP;
            end else if (c == CH_PLUS) begin
               phase_nx = PH_EXP;
            end else if (c == CH_NUL) begin
               phase_nx   = PH_DONE;
               outcome_nx = ST_OK;
            end else begin
               op       = OP_EXP_LOAD;
               phase_nx = PH_EXP;
            end
         end
         PH_EXP: begin
            raw      = dec_raw;
            use_eneg = 1'b1;
            if (c == CH_NUL) begin
               phase_nx   = PH_DONE;
               outcome_nx = ST_OK;
            end else begin
               op = OP_EXP_STEP;
            end
         end
         default: begin
         end
      endcase
   end

   // command: signed digit folded here so the back end only adds
   always_comb begin
      cmd.op   = op;
      cmd.last = req_if.last_char;
      if ((use_eneg && eneg_ff) || (!use_eneg && mneg_ff && op != OP_EXP_LOAD)) begin
         cmd.digit = -raw;
      end else begin
         cmd.digit = raw;
      end
      cmd.status = (phase_nx == PH_DONE) ? outcome_nx : ST_OUTRUN;
      cmd_push   = accept && (op != OP_NONE || req_if.last_char);
   end

   always_comb begin
      phase_in    = phase_ff;
      mneg_in     = mneg_ff;
      eneg_in     = eneg_ff;
      mismatch_in = mismatch_ff;
      outcome_in  = outcome_ff;
      if (accept) begin
         if (req_if.last_char) begin
            phase_in    = PH_START;
            mneg_in     = 1'b0;
            eneg_in     = 1'b0;
            mismatch_in = 1'b0;
            outcome_in  = ST_OK;
         end else begin
            phase_in    = phase_nx;
            mneg_in     = mneg_nx;
            eneg_in     = eneg_nx;
            mismatch_in = mismatch_nx;
            outcome_in  = outcome_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         mneg_ff     <= 1'b0;
         eneg_ff     <= 1'b0;
         mismatch_ff <= 1'b0;
         outcome_ff  <= ST_OK;
      end else begin
         phase_ff    <= phase_in;
         mneg_ff     <= mneg_in;
         eneg_ff     <= eneg_in;
         mismatch_ff <= mismatch_in;
         outcome_ff  <= outcome_in;
      end
   end

endmodule

// ----- rtl/hfp_cmd_fifo.sv -----
// Two-entry command queue between front and back end.
// Depends on hfp_pkg.
module hfp_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hfp_pkg::hfp_cmd_type wr_cmd,
   output logic                 full,
   input  logic                 pop,
   output hfp_pkg::hfp_cmd_type rd_cmd,
   output logic                 empty
);
   import hfp_pkg::*;

   hfp_cmd_type entry_ff [2];
   hfp_cmd_type entry_in [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full   = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign rd_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = wr_cmd;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/hfp_back.sv -----
// Back end: mantissa/exponent accumulators and the result register.
// Depends on hfp_pkg.
module hfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  hfp_pkg::hfp_cmd_type cmd,
   output logic                 cmd_pop,
   hfp_rsp_if.source            rsp_if
);
   import hfp_pkg::*;

   logic signed [VAL_W-1:0]  mant_ff, mant_in;
   logic signed [VAL_W-1:0]  exp_ff, exp_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_mant_ff, rsp_mant_in;
   logic signed [VAL_W-1:0]  rsp_exp_ff, rsp_exp_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   logic                     out_free;
   logic signed [VAL_W-1:0]  digit_ext;
   logic [VAL_W-1:0]         frac_scaled;

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign cmd_pop     = cmd_valid && (!cmd.last || out_free);
   assign digit_ext   = VAL_W'(cmd.digit);
   assign frac_scaled = {{(VAL_W-FRAC_W-2){1'b0}}, frac_ff, 2'b00};

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.mantissa = rsp_mant_ff;
   assign rsp_if.exponent = rsp_exp_ff;
   assign rsp_if.status   = rsp_status_ff;

   always_comb begin
      mant_in       = mant_ff;
      exp_in        = exp_ff;
      frac_in       = frac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_mant_in   = rsp_mant_ff;
      rsp_exp_in    = rsp_exp_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd_pop) begin
         if (cmd.last) begin
            // result from state so far; a good result never ends on a digit
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            if (cmd.status == ST_OK) begin
               rsp_mant_in = mant_ff;
               rsp_exp_in  = exp_ff - $signed(frac_scaled);
            end else begin
               rsp_mant_in = '0;
               rsp_exp_in  = '0;
            end
            mant_in = '0;
            exp_in  = '0;
            frac_in = '0;
         end else begin
            case (cmd.op)
               OP_MANT_LOAD: begin
                  mant_in = digit_ext;
               end
               OP_MANT_SHIFT: begin
                  mant_in = (mant_ff <<< 4) + digit_ext;
                  frac_in = frac_ff + FRAC_W'(1);
               end
               OP_EXP_LOAD: begin
                  exp_in = digit_ext;
               end
               OP_EXP_STEP: begin
                  // times ten, sign already folded into the digit
                  exp_in = (exp_ff <<< 3) + (exp_ff <<< 1) + digit_ext;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_mant_ff   <= rsp_mant_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         mant_ff      <= '0;
         exp_ff       <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mant_ff      <= mant_in;
         exp_ff       <= exp_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/hex_float_string_parser_core.sv -----
// Hex float string parser top level: one byte per beat, one result per string.
// Throughput: one byte per cycle while no held result stalls the back end;
// the front end classifies, a two-entry command queue feeds the accumulator
// back end. The last byte passes through the queue register, then the result
// register, before the result beat is valid.
// Reset: synchronous, active high; clears parse state, queue and result valid.
module hex_float_string_parser_core (
   input  logic      clock,
   input  logic      reset,
   hfp_req_if.sink   req_if,
   hfp_rsp_if.source rsp_if
);
   import hfp_pkg::*;

   hfp_cmd_type push_cmd;
   hfp_cmd_type head_cmd;
   logic        cmd_push;
   logic        cmd_pop;
   logic        cmd_full;
   logic        cmd_empty;

   hfp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd      (push_cmd)
   );

   hfp_cmd_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (push_cmd),
      .full   (cmd_full),
      .pop    (cmd_pop),
      .rd_cmd (head_cmd),
      .empty  (cmd_empty)
   );

   hfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- test/tb_hex_float_string_parser_core.sv -----
// Self-checking testbench for hex_float_string_parser_core: random and directed strings,
// one byte per beat, results checked against a behavioural parser in the bench.
// Depends on hfp_pkg, hfp_req_if, hfp_rsp_if and the core.
module tb_hex_float_string_parser_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hfp_pkg::*;

   localparam int PERIOD     = 4;
   localparam int CYCLE_CAP  = 400000;
   localparam int RAND_BYTES = 760;
   localparam int CALM_FROM  = 300;
   localparam int CALM_TO    = 700;

   localparam logic [3:0] PH_START = 4'd0;
   localparam logic [3:0] PH_ZERO  = 4'd1;
   localparam logic [3:0] PH_X     = 4'd2;
   localparam logic [3:0] PH_LEAD  = 4'd3;
   localparam logic [3:0] PH_DOT   = 4'd4;
   localparam logic [3:0] PH_FRAC  = 4'd5;
   localparam logic [3:0] PH_ESIGN = 4'd6;
   localparam logic [3:0] PH_EXP   = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              is_last;
      bit                drain;   // not a beat: hold off until all results are back
   } char_beat_type;

   typedef struct {
      logic signed [VAL_W-1:0] mantissa;
      logic signed [VAL_W-1:0] exponent;
      logic [STATUS_W-1:0]     status;
   } parsed_value_type;

   logic clock;
   logic reset;

   hfp_req_if req_ch();
   hfp_rsp_if rsp_ch();

   hex_float_string_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   char_beat_type    char_q[$];
   parsed_value_type value_q[$];
   parsed_value_type want;

   // bench copy of the parse state
   logic [3:0]         phase;
   logic               mant_neg;
   logic [VAL_W-1:0]   mant_acc;
   logic [VAL_W-1:0]   exp_acc;
   logic               exp_neg;
   logic [FRAC_W-1:0]  frac_cnt;
   logic               prefix_bad;
   logic [STATUS_W-1:0] outcome;

   int  fail_cnt = 0;
   int  cycle_cnt = 0;
   bit  byte_taken = 1'b0;
   bit  calm;

   initial clock = 1'b0;
   always #(PERIOD/2) clock = ~clock;

   assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

   function automatic logic [VAL_W-1:0] digit_weight(input logic [CHAR_W-1:0] c);
      if (c >= CH_LC_A)
         return {56'd0, c} - {56'd0, CH_LC_A} + 64'd10;
      return {56'd0, c} - {56'd0, CH_ZERO};
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char();
      int v;
      v = $urandom_range(15);
      if ($urandom_range(7) == 0)
         return 8'($urandom_range(255));   // digits are not validated
      return (v < 10) ? CH_ZERO + 8'(v) : CH_LC_A + 8'(v - 10);
   endfunction

   task automatic clear_parse();
      phase      = PH_START;
      mant_neg   = 1'b0;
      mant_acc   = '0;
      exp_acc    = '0;
      exp_neg    = 1'b0;
      frac_cnt   = '0;
      prefix_bad = 1'b0;
      outcome    = ST_OK;
   endtask

   task automatic settle(input logic [STATUS_W-1:0] st);
      outcome = st;
      phase   = PH_DONE;
   endtask

   task automatic parse_char(input logic [CHAR_W-1:0] c, input logic is_last);
      parsed_value_type r;
      logic [STATUS_W-1:0] st;
      case (phase)
         PH_START: begin
            if (c == CH_MINUS) begin
               mant_neg = 1'b1;
               phase = PH_ZERO;
            end else begin
               if (c != CH_ZERO) prefix_bad = 1'b1;
               phase = PH_X;
            end
         end
         PH_ZERO: begin
            if (c != CH_ZERO) prefix_bad = 1'b1;
            phase = PH_X;
         end
         PH_X: begin
            if (c != CH_LC_X) prefix_bad = 1'b1;
            phase = PH_LEAD;
         end
         PH_LEAD: begin
            if (prefix_bad) begin
               settle(ST_NO_0X);
            end else begin
               mant_acc = digit_weight(c);
               phase = PH_DOT;
            end
         end
         PH_DOT: begin
            if (c == CH_DOT) begin
               phase = PH_FRAC;
               if (is_last) settle(ST_NO_P);
            end else if (c == CH_LC_P) begin
               phase = PH_ESIGN;
            end else begin
               settle(ST_NO_P);
            end
         end
         PH_FRAC: begin
            if (c == CH_LC_P) begin
               phase = PH_ESIGN;
            end else begin
               mant_acc = (mant_acc << 4) + digit_weight(c);
               frac_cnt = frac_cnt + 32'd1;
               if (is_last) settle(ST_NO_P);
            end
         end
         PH_ESIGN: begin
            if (c == CH_MINUS) begin
               exp_neg = 1'b1;
               phase = PH_EXP;
            end else if (c == CH_PLUS) begin
               phase = PH_EXP;
            end else if (c == CH_NUL) begin
               settle(ST_OK);
            end else begin
               exp_acc = {56'd0, c} - {56'd0, CH_ZERO};
               phase = PH_EXP;
            end
         end
         PH_EXP: begin
            if (c == CH_NUL)
               settle(ST_OK);
            else
               exp_acc = exp_acc * 64'd10 + ({56'd0, c} - {56'd0, CH_ZERO});
         end
         default: ;
      endcase

      if (is_last) begin
         st = (phase == PH_DONE) ? outcome : ST_OUTRUN;
         r.mantissa = '0;
         r.exponent = '0;
         r.status   = st;
         if (st == ST_OK) begin
            r.mantissa = mant_neg ? -mant_acc : mant_acc;
            r.exponent = (exp_neg ? -exp_acc : exp_acc) - {30'd0, frac_cnt, 2'b00};
         end
         value_q.push_back(r);
         clear_parse();
      end
   endtask

   task automatic push_char(input logic [CHAR_W-1:0] c);
      char_q.push_back('{code: c, is_last: 1'b0, drain: 1'b0});
   endtask

   task automatic end_string();
      char_q[char_q.size()-1].is_last = 1'b1;
   endtask

   task automatic push_drain();
      char_q.push_back('{code: CH_NUL, is_last: 1'b0, drain: 1'b1});
   endtask

   task automatic queue_text(input string head, input bit nul_end, input string tail);
      for (int i = 0; i < head.len(); i++) push_char(head[i]);
      if (nul_end) push_char(CH_NUL);
      for (int i = 0; i < tail.len(); i++) push_char(tail[i]);
      end_string();
   endtask

   // mostly well-formed strings with random content; some truncated, broken or plain noise
   task automatic queue_random_string();
      logic [CHAR_W-1:0] s[$];
      int kind;
      int n_frac;
      int n_exp;
      int cut;
      kind = $urandom_range(99);
      if (kind >= 90) begin
         repeat ($urandom_range(8, 1)) s.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0) s.push_back(CH_MINUS);
         s.push_back((kind >= 80 && $urandom_range(1)) ? 8'($urandom_range(255)) : CH_ZERO);
         s.push_back((kind >= 80 && $urandom_range(1)) ? 8'($urandom_range(255)) : CH_LC_X);
         s.push_back(hex_char());
         n_frac = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(6);
         if (n_frac != 0 || $urandom_range(1)) begin
            s.push_back(CH_DOT);
            repeat (n_frac) s.push_back(hex_char());
         end
         s.push_back((kind >= 75 && kind < 80) ? 8'($urandom_range(255)) : CH_LC_P);
         case ($urandom_range(3))
            0: s.push_back(CH_MINUS);
            1: s.push_back(CH_PLUS);
            default: ;
         endcase
         n_exp = ($urandom_range(9) == 0) ? $urandom_range(25) : $urandom_range(4);
         repeat (n_exp) begin
            if ($urandom_range(15) == 0)
               s.push_back(8'($urandom_range(255, 1)));
            else
               s.push_back(CH_ZERO + 8'($urandom_range(9)));
         end
         if (kind < 70 || $urandom_range(1)) s.push_back(CH_NUL);
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(3, 1)) s.push_back(8'($urandom_range(255)));
         if (kind >= 60 && $urandom_range(2) == 0) begin
            cut = $urandom_range(s.size() - 1);
            while (s.size() > cut + 1) s.delete(s.size() - 1);
         end
      end
      foreach (s[i]) push_char(s[i]);
      end_string();
   endtask

   // input acceptance, result check, cycle cap
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (reset) begin
         byte_taken = 1'b0;
      end else begin
         byte_taken = req_ch.valid && req_ch.ready;
         if (byte_taken) begin
            parse_char(req_ch.char_code, req_ch.last_char);
            void'(char_q.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (value_q.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= 10)
                  $display("unexpected result beat: mantissa %h exponent %h status %0d",
                           rsp_ch.mantissa, rsp_ch.exponent, rsp_ch.status);
            end else begin
               want = value_q.pop_front();
               if (rsp_ch.mantissa !== want.mantissa || rsp_ch.exponent !== want.exponent ||
                   rsp_ch.status !== want.status) begin
                  fail_cnt++;
                  if (fail_cnt <= 10)
                     $display("mismatch (exp/got): mant %h/%h expo %h/%h status %0d/%0d",
                              want.mantissa, rsp_ch.mantissa, want.exponent, rsp_ch.exponent,
                              want.status, rsp_ch.status);
               end
            end
         end
      end
   end

   // byte driver and result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !byte_taken)) begin
         if (char_q.size() != 0 && char_q[0].drain) begin
            req_ch.valid <= 1'b0;
            if (value_q.size() == 0) void'(char_q.pop_front());
         end else if (char_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
            req_ch.valid     <= 1'b1;
            req_ch.char_code <= char_q[0].code;
            req_ch.last_char <= char_q[0].is_last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
      rsp_ch.ready <= calm || ($urandom_range(99) >= 12);
   end

   initial begin
      int base;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.last_char = 1'b0;
      rsp_ch.ready     = 1'b0;
      clear_parse();

      queue_text("0x1.8p3", 1'b1, "");
      queue_text("-0xa.bcp-12", 1'b1, "");
      queue_text("0xf.fp+7", 1'b1, "");
      queue_text("0x1.p", 1'b1, "");
      queue_text("0x1p", 1'b1, "");           // NUL straight after p: exponent zero
      queue_text("0x1p3", 1'b1, "zz");        // bytes after the decision are ignored
      queue_text("0x1.", 1'b0, "");           // ends on the point
      queue_text("0x1.8", 1'b0, "");          // ends in the fraction
      queue_text("0x1q", 1'b0, "");           // neither point nor p
      queue_text("0y12", 1'b0, "");           // bad prefix
      queue_text("-", 1'b0, "");
      queue_text("0x", 1'b0, "");
      queue_text("0x1p", 1'b0, "");           // ends on p
      queue_text("0x1p-", 1'b0, "");          // ends on exponent sign
      queue_text("0x1p12", 1'b0, "");         // no NUL terminator
      // byte extremes in digit positions
      push_char(CH_ZERO); push_char(CH_LC_X); push_char(8'hff); push_char(CH_DOT);
      push_char(8'h00); push_char(8'hff); push_char(CH_LC_P); push_char(8'hff);
      push_char(8'hff); push_char(CH_NUL);
      end_string();
      push_drain();

      base = char_q.size();
      while (char_q.size() - base < RAND_BYTES) begin
         queue_random_string();
         if ($urandom_range(29) == 0) push_drain();
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || value_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
